/* hdl/crast_pkg.sv */
// ----------------------------------------------------------------------------
// crast_pkg
// Shared codes and fixed sizes of the circle rasterizer core.
// ----------------------------------------------------------------------------
package crast_pkg;

    // Input item kind, carried in s_axis_tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // fill_mode register values
    localparam logic MODE_OUTLINE = 1'b0;
    localparam logic MODE_FILLED  = 1'b1;

    // Results per iteration, and the counter that walks them
    localparam int unsigned SLOT_BITS = 3;
    typedef logic [SLOT_BITS-1:0] slot_t;

    localparam slot_t OUTLINE_LAST = slot_t'(7);
    localparam slot_t FILLED_LAST  = slot_t'(3);

endpackage

/* hdl/circle_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// circle_rasterizer_core
// Andres circle generator: outline points or filled horizontal spans.
// ----------------------------------------------------------------------------
// Each item's results pass the iteration registers (job_*), then the result register.
// An item gives eight points in outline mode and four spans in filled mode; the
// output register sends one point or span per cycle unless m_axis_tready stalls it;
// a step with no figure active gives no result. The next item is taken as the last result loads.
// Reset: asynchronous, clears the figure state, fill_mode and both valid flags.
module circle_rasterizer_core
    import crast_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data,      // fill_mode

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // center_x, center_y, radius, zero fill
    input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tuser,  // action

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // span_x_start, span_x_end, span_row, zero fill
    output logic [((3*(COORD_BITS+1)+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast,  // last_of_step
    output logic m_axis_tuser   // figure_done
);

    localparam int OUT_BITS = COORD_BITS + 1;
    localparam int OFF_BITS = RADIUS_BITS + 1;
    localparam int DEC_BITS = RADIUS_BITS + 3;
    localparam int AW       = RADIUS_BITS + 4;
    localparam int SUM_W    = (OUT_BITS > RADIUS_BITS + 2) ? OUT_BITS : RADIUS_BITS + 2;
    localparam int OUT_W    = ((3*OUT_BITS+7)/8)*8;

    // figure state
    logic                       fill_mode_reg;
    logic                       busy_reg, busy_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic        [RADIUS_BITS-1:0] rad_reg, rad_next;
    logic signed [OFF_BITS-1:0] off_x_reg, off_x_next;
    logic signed [OFF_BITS-1:0] off_y_reg, off_y_next;
    logic signed [DEC_BITS-1:0] dec_reg, dec_next;

    // iteration being sent
    logic                         job_valid_reg, job_valid_next;
    logic signed [COORD_BITS-1:0] job_x_reg, job_x_next;
    logic signed [COORD_BITS-1:0] job_y_reg, job_y_next;
    logic signed [OFF_BITS-1:0]   job_ox_reg, job_ox_next;
    logic signed [OFF_BITS-1:0]   job_oy_reg, job_oy_next;
    logic                         job_done_reg, job_done_next;
    logic                         job_fill_reg, job_fill_next;
    slot_t                        job_k_reg, job_k_next;

    // result register
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic             m_user_reg, m_user_next;

    logic s_xfer, is_start, emits, load, job_last;

    logic signed [COORD_BITS-1:0]  in_cx, in_cy;
    logic        [RADIUS_BITS-1:0] in_rad;

    logic signed [AW-1:0] ox0, oy0, d0, r0, ox1, oy1, d1;
    logic                 done1;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_mode_reg <= MODE_OUTLINE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fill_mode_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input side and one iteration of the circle recurrence
    // ------------------------------------------------------------------
    assign in_cx  = s_axis_tdata[COORD_BITS-1:0];
    assign in_cy  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_rad = s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];

    assign load     = job_valid_reg && (!m_valid_reg || m_axis_tready);
    assign job_last = job_k_reg == (job_fill_reg ? FILLED_LAST : OUTLINE_LAST);

    assign s_axis_tready = !job_valid_reg || (load && job_last);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign is_start      = s_axis_tuser == ACT_START;
    assign emits         = is_start || busy_reg;

    always_comb
    begin
        if (is_start)
        begin
            ox0 = '0;
            oy0 = AW'({1'b0, in_rad});
            r0  = AW'({1'b0, in_rad});
            d0  = AW'({1'b0, in_rad}) - AW'(1);
        end
        else
        begin
            ox0 = AW'(off_x_reg);
            oy0 = AW'(off_y_reg);
            r0  = AW'({1'b0, rad_reg});
            d0  = AW'(dec_reg);
        end

        if (d0 >= (ox0 <<< 1))
        begin
            d1  = d0 - (ox0 <<< 1) - AW'(1);
            ox1 = ox0 + AW'(1);
            oy1 = oy0;
        end
        else if (d0 < ((r0 - oy0) <<< 1))
        begin
            d1  = d0 + (oy0 <<< 1) - AW'(1);
            ox1 = ox0;
            oy1 = oy0 - AW'(1);
        end
        else
        begin
            d1  = d0 + ((oy0 - ox0 - AW'(1)) <<< 1);
            ox1 = ox0 + AW'(1);
            oy1 = oy0 - AW'(1);
        end
        done1 = oy1 < ox1;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rad_next   = rad_reg;
        off_x_next = off_x_reg;
        off_y_next = off_y_reg;
        dec_next   = dec_reg;

        job_valid_next = job_valid_reg;
        job_x_next     = job_x_reg;
        job_y_next     = job_y_reg;
        job_ox_next    = job_ox_reg;
        job_oy_next    = job_oy_reg;
        job_done_next  = job_done_reg;
        job_fill_next  = job_fill_reg;
        job_k_next     = job_k_reg;

        // advance through the results of the current iteration
        if (load)
        begin
            if (job_last)
            begin
                job_valid_next = 1'b0;
            end
            job_k_next = job_k_reg + slot_t'(1);
        end

        if (s_xfer && emits)
        begin
            if (is_start)
            begin
                cx_next  = in_cx;
                cy_next  = in_cy;
                rad_next = in_rad;
            end
            off_x_next = ox1[OFF_BITS-1:0];
            off_y_next = oy1[OFF_BITS-1:0];
            dec_next   = d1[DEC_BITS-1:0];
            busy_next  = !done1;

            job_valid_next = 1'b1;
            job_x_next     = is_start ? in_cx : cx_reg;
            job_y_next     = is_start ? in_cy : cy_reg;
            job_ox_next    = ox0[OFF_BITS-1:0];
            job_oy_next    = oy0[OFF_BITS-1:0];
            job_done_next  = done1;
            job_fill_next  = fill_mode_reg;
            job_k_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            rad_reg       <= '0;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            dec_reg       <= '0;
            job_valid_reg <= 1'b0;
            job_k_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            rad_reg       <= rad_next;
            off_x_reg     <= off_x_next;
            off_y_reg     <= off_y_next;
            dec_reg       <= dec_next;
            job_valid_reg <= job_valid_next;
            job_k_reg     <= job_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_x_reg    <= job_x_next;
        job_y_reg    <= job_y_next;
        job_ox_reg   <= job_ox_next;
        job_oy_reg   <= job_oy_next;
        job_done_reg <= job_done_next;
        job_fill_reg <= job_fill_next;
    end

    // ------------------------------------------------------------------
    // Mirrored coordinates and result selection
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] xw, yw, oxw, oyw;
    logic [OUT_BITS-1:0] x_p_ox, x_m_ox, x_p_oy, x_m_oy;
    logic [OUT_BITS-1:0] y_p_ox, y_m_ox, y_p_oy, y_m_oy;
    logic [OUT_BITS-1:0] sel_xs, sel_xe, sel_row;

    assign xw  = SUM_W'(job_x_reg);
    assign yw  = SUM_W'(job_y_reg);
    assign oxw = SUM_W'(job_ox_reg);
    assign oyw = SUM_W'(job_oy_reg);

    // outputs wrap to OUT_BITS
    always_comb
    begin
        logic signed [SUM_W-1:0] s0, s1, s2, s3, s4, s5, s6, s7;
        s0 = xw + oxw;
        s1 = xw - oxw;
        s2 = xw + oyw;
        s3 = xw - oyw;
        s4 = yw + oxw;
        s5 = yw - oxw;
        s6 = yw + oyw;
        s7 = yw - oyw;
        x_p_ox = s0[OUT_BITS-1:0];
        x_m_ox = s1[OUT_BITS-1:0];
        x_p_oy = s2[OUT_BITS-1:0];
        x_m_oy = s3[OUT_BITS-1:0];
        y_p_ox = s4[OUT_BITS-1:0];
        y_m_ox = s5[OUT_BITS-1:0];
        y_p_oy = s6[OUT_BITS-1:0];
        y_m_oy = s7[OUT_BITS-1:0];
    end

    always_comb
    begin
        sel_xs  = x_p_ox;
        sel_xe  = x_p_ox;
        sel_row = y_p_oy;
        if (job_fill_reg == MODE_FILLED)
        begin
            case (job_k_reg[1:0])
                2'd0:
                begin
                    sel_xs = x_m_oy; sel_xe = x_p_oy; sel_row = y_p_ox;
                end
                2'd1:
                begin
                    sel_xs = x_m_ox; sel_xe = x_p_ox; sel_row = y_p_oy;
                end
                2'd2:
                begin
                    sel_xs = x_m_ox; sel_xe = x_p_ox; sel_row = y_m_oy;
                end
                default:
                begin
                    sel_xs = x_m_oy; sel_xe = x_p_oy; sel_row = y_m_ox;
                end
            endcase
        end
        else
        begin
            case (job_k_reg)
                3'd0:    begin sel_xs = x_p_ox; sel_row = y_p_oy; end
                3'd1:    begin sel_xs = x_p_oy; sel_row = y_p_ox; end
                3'd2:    begin sel_xs = x_m_ox; sel_row = y_p_oy; end
                3'd3:    begin sel_xs = x_m_oy; sel_row = y_p_ox; end
                3'd4:    begin sel_xs = x_p_ox; sel_row = y_m_oy; end
                3'd5:    begin sel_xs = x_p_oy; sel_row = y_m_ox; end
                3'd6:    begin sel_xs = x_m_ox; sel_row = y_m_oy; end
                default: begin sel_xs = x_m_oy; sel_row = y_m_ox; end
            endcase
            sel_xe = sel_xs;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        if (load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({sel_row, sel_xe, sel_xs});
            m_last_next  = job_last;
            m_user_next  = job_done_reg;
        end
        else if (m_axis_tready)
        begin
            // drop the result once transferred
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && job_fill_reg == MODE_FILLED) |-> job_k_reg <= FILLED_LAST)
        else $error("filled iteration walked past its fourth span");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && is_start && !done1) |=> busy_reg)
        else $error("start transfer did not open a figure");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && job_done_reg) |-> !busy_reg)
        else $error("figure still active while its final iteration is sent");

    a_busy_order: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> off_y_reg >= off_x_reg)
        else $error("active figure has crossed the diagonal");

    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (load && job_last && !s_xfer) |=> !job_valid_reg)
        else $error("iteration kept sending after its last result");

endmodule
